// ----- hw/rtl/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants for the snow crystal cell update
// Fixed point formats, request and result structs, register indexes and
// small helpers used by both datapath slices.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

	// value format, unsigned Q8.24
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 24;
	// fractions are Q0.24 with room for exactly 1.0
	localparam int FRACT_W   = FRAC_W + 1;
	localparam int NBR_N     = 6;
	// sum of own value and six neighbours never overflows this width
	localparam int SUM_W     = VAL_W + 3;
	localparam int CNT_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = VAL_W;

	localparam logic [VAL_W-1:0]   VAL_MAX = '1;
	localparam logic [FRACT_W-1:0] ONE_FR  = {1'b1, {FRAC_W{1'b0}}};
	localparam logic [VAL_W-1:0]   ONE_FX  = {{(VAL_W-FRACT_W){1'b0}}, ONE_FR};

	// cell kinds and phases
	localparam logic [1:0] KIND_OUTSIDE  = 2'd0;
	localparam logic [1:0] KIND_VAPOUR   = 2'd1;
	localparam logic       PHASE_DIFFUSE = 1'b0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAR_FIELD,
		CFG_THR_SPARSE,
		CFG_THR_THREE,
		CFG_LIM_THREE,
		CFG_KAPPA,
		CFG_MU,
		CFG_GAMMA
	} cfg_reg_e;

	typedef struct packed {
		logic             req_type;
		logic [1:0]       cell_kind;
		logic [VAL_W-1:0] own_vapour;
		logic [VAL_W-1:0] nbr_vapour_0;
		logic [VAL_W-1:0] nbr_vapour_1;
		logic [VAL_W-1:0] nbr_vapour_2;
		logic [VAL_W-1:0] nbr_vapour_3;
		logic [VAL_W-1:0] nbr_vapour_4;
		logic [VAL_W-1:0] nbr_vapour_5;
		logic [NBR_N-1:0] nbr_crystal_mask;
		logic [VAL_W-1:0] boundary_mass_in;
		logic [VAL_W-1:0] crystal_mass_in;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] vapour_out;
		logic [VAL_W-1:0] boundary_mass_out;
		logic [VAL_W-1:0] crystal_mass_out;
		logic             attached;
	} rsp_t;

	typedef struct packed {
		logic [VAL_W-1:0]   far_field_vapour;
		logic [VAL_W-1:0]   attach_threshold_sparse;
		logic [VAL_W-1:0]   attach_threshold_three;
		logic [VAL_W-1:0]   vapour_limit_three;
		logic [FRACT_W-1:0] freeze_fraction;
		logic [FRACT_W-1:0] melt_boundary_fraction;
		logic [FRACT_W-1:0] melt_crystal_fraction;
	} cfg_t;

	typedef logic [NBR_N-1:0][VAL_W-1:0] nbr_arr_t;

	// neighbour values as an indexable array
	function automatic nbr_arr_t nbr_list(input req_t r);
		nbr_arr_t v;
		v[0] = r.nbr_vapour_0;
		v[1] = r.nbr_vapour_1;
		v[2] = r.nbr_vapour_2;
		v[3] = r.nbr_vapour_3;
		v[4] = r.nbr_vapour_4;
		v[5] = r.nbr_vapour_5;
		return v;
	endfunction

	// balanced adder tree over own value and six neighbours
	function automatic logic [SUM_W-1:0] sum_terms(input logic [VAL_W-1:0] own,
		input nbr_arr_t t);
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
		logic [SUM_W-1:0] c;
		a = SUM_W'(t[0]) + SUM_W'(t[1]);
		b = SUM_W'(t[2]) + SUM_W'(t[3]);
		c = SUM_W'(t[4]) + SUM_W'(t[5]);
		return (a + b) + (c + SUM_W'(own));
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hsc_cfg_regs: configuration register file
// Holds rho, beta, alpha, theta, kappa, mu and gamma; one write per request
// on a valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output hsc_pkg::cfg_t                  cfg
);
	import hsc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.far_field_vapour        <= ONE_FX;
			cfg_q.attach_threshold_sparse <= ONE_FX;
			cfg_q.attach_threshold_three  <= ONE_FX;
			cfg_q.vapour_limit_three      <= ONE_FX;
			cfg_q.freeze_fraction         <= '0;
			cfg_q.melt_boundary_fraction  <= '0;
			cfg_q.melt_crystal_fraction   <= '0;
		end else if (wr_en) begin
			case (cfg_index)
				CFG_FAR_FIELD:  cfg_q.far_field_vapour        <= cfg_wdata[VAL_W-1:0];
				CFG_THR_SPARSE: cfg_q.attach_threshold_sparse <= cfg_wdata[VAL_W-1:0];
				CFG_THR_THREE:  cfg_q.attach_threshold_three  <= cfg_wdata[VAL_W-1:0];
				CFG_LIM_THREE:  cfg_q.vapour_limit_three      <= cfg_wdata[VAL_W-1:0];
				CFG_KAPPA:      cfg_q.freeze_fraction         <= cfg_wdata[FRACT_W-1:0];
				CFG_MU:         cfg_q.melt_boundary_fraction  <= cfg_wdata[FRACT_W-1:0];
				CFG_GAMMA:      cfg_q.melt_crystal_fraction   <= cfg_wdata[FRACT_W-1:0];
				default: ;
			endcase
		end
	end

	// a kappa write lands in the register on the next cycle
	a_kappa_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && cfg_index == CFG_KAPPA
		|=> cfg_q.freeze_fraction == $past(cfg_wdata[FRACT_W-1:0]))
		else $error("kappa write not stored");

endmodule

`default_nettype wire

// ----- hw/rtl/hsc_diffuse.sv -----
// ----------------------------------------------------------------------------
// hsc_diffuse: diffusion phase datapath
// Seven-term neighbourhood sum, division by seven through a split reciprocal
// multiply and a remainder correction, three register stages inside.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_diffuse (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s4,
	input  hsc_pkg::req_t              req,
	input  logic [hsc_pkg::VAL_W-1:0]  far_field,
	output hsc_pkg::rsp_t              rsp
);
	import hsc_pkg::*;

	// reciprocal of seven scaled so the quotient estimate is short by at most two
	localparam int RECIP_SHIFT = SUM_W - 1;
	localparam logic [VAL_W-1:0] RECIP = VAL_W'((65'd1 << RECIP_SHIFT) / 65'd7);
	localparam int LO_W   = SUM_W / 2;
	localparam int HI_W   = SUM_W - LO_W;
	localparam int PHI_W  = HI_W + VAL_W;
	localparam int PLO_W  = LO_W + VAL_W;
	localparam int PROD_W = SUM_W + VAL_W;
	localparam int REM_W  = 5;
	localparam logic [REM_W-1:0] DIV7  = REM_W'(7);
	localparam logic [REM_W-1:0] DIV14 = REM_W'(14);

	nbr_arr_t         nbr_raw;
	nbr_arr_t         nbr_sub;
	logic [SUM_W-1:0] sum_d;

	logic [SUM_W-1:0] sum_s2;
	logic             avg_s2;
	logic [VAL_W-1:0] fixed_s2;
	logic [VAL_W-1:0] bm_s2;
	logic [VAL_W-1:0] cm_s2;

	logic [PHI_W-1:0] pp_hi_s3;
	logic [PLO_W-1:0] pp_lo_s3;
	logic [SUM_W-1:0] sum_s3;
	logic             avg_s3;
	logic [VAL_W-1:0] fixed_s3;
	logic [VAL_W-1:0] bm_s3;
	logic [VAL_W-1:0] cm_s3;

	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0]  q0_s4;
	logic [SUM_W-1:0]  sum_s4;
	logic              avg_s4;
	logic [VAL_W-1:0]  fixed_s4;
	logic [VAL_W-1:0]  bm_s4;
	logic [VAL_W-1:0]  cm_s4;

	logic [SUM_W-1:0] q_times7;
	logic [SUM_W-1:0] rem_wide;
	logic [REM_W-1:0] rem_raw;
	logic [1:0]       corr;
	logic [REM_W-1:0] rem_fix;
	logic [VAL_W-1:0] quot;

	// crystal neighbours count as the cell's own vapour
	always_comb begin
		nbr_raw = nbr_list(req);
		for (int q = 0; q < NBR_N; q++) begin
			nbr_sub[q] = req.nbr_crystal_mask[q] ? req.own_vapour : nbr_raw[q];
		end
		sum_d = sum_terms(req.own_vapour, nbr_sub);
	end

	// stage 2: sum and fixed answers for reservoir and crystal cells
	always_ff @(posedge clk) begin
		sum_s2   <= sum_d;
		avg_s2   <= (req.cell_kind == KIND_VAPOUR);
		fixed_s2 <= (req.cell_kind == KIND_OUTSIDE) ? far_field : '0;
		bm_s2    <= req.boundary_mass_in;
		cm_s2    <= req.crystal_mass_in;
	end

	// stage 3: two partial products of sum times reciprocal
	always_ff @(posedge clk) begin
		pp_hi_s3 <= PHI_W'(sum_s2[SUM_W-1:LO_W]) * PHI_W'(RECIP);
		pp_lo_s3 <= PLO_W'(sum_s2[LO_W-1:0]) * PLO_W'(RECIP);
		sum_s3   <= sum_s2;
		avg_s3   <= avg_s2;
		fixed_s3 <= fixed_s2;
		bm_s3    <= bm_s2;
		cm_s3    <= cm_s2;
	end

	// stage 4: combine partial products into the quotient estimate
	assign prod = (PROD_W'(pp_hi_s3) << LO_W) + PROD_W'(pp_lo_s3);

	always_ff @(posedge clk) begin
		q0_s4    <= prod[RECIP_SHIFT +: VAL_W];
		sum_s4   <= sum_s3;
		avg_s4   <= avg_s3;
		fixed_s4 <= fixed_s3;
		bm_s4    <= bm_s3;
		cm_s4    <= cm_s3;
	end

	// remainder check, estimate is exact or one or two short
	always_comb begin
		q_times7 = (SUM_W'(q0_s4) << 3) - SUM_W'(q0_s4);
		rem_wide = sum_s4 - q_times7;
		rem_raw  = rem_wide[REM_W-1:0];
		if (rem_raw >= DIV14) begin
			corr    = 2'd2;
			rem_fix = rem_raw - DIV14;
		end else if (rem_raw >= DIV7) begin
			corr    = 2'd1;
			rem_fix = rem_raw - DIV7;
		end else begin
			corr    = 2'd0;
			rem_fix = rem_raw;
		end
		quot = q0_s4 + VAL_W'(corr);
	end

	// phase 0 result, masses pass through
	always_comb begin
		rsp.vapour_out        = avg_s4 ? quot : fixed_s4;
		rsp.boundary_mass_out = bm_s4;
		rsp.crystal_mass_out  = cm_s4;
		rsp.attached          = 1'b0;
	end

	// corrected quotient leaves a remainder below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && avg_s4 |-> rem_fix < DIV7 && rem_wide[SUM_W-1:REM_W] == '0)
		else $error("divide by seven correction out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/hsc_freeze.sv -----
// ----------------------------------------------------------------------------
// hsc_freeze: freeze, attach and melt phase datapath
// Kappa split of the vapour, saturating mass update, attachment decision by
// neighbour count, then mu and gamma melt; three register stages inside.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_freeze (
	input  logic          clk,
	input  hsc_pkg::req_t req,
	input  hsc_pkg::cfg_t cfg,
	output hsc_pkg::rsp_t rsp
);
	import hsc_pkg::*;

	localparam int PK_W = VAL_W + FRACT_W;
	localparam logic [CNT_W-1:0] SPARSE_MAX = CNT_W'(2);
	localparam logic [CNT_W-1:0] THREE_NBR  = CNT_W'(3);

	function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
	endfunction

	function automatic logic [FRACT_W-1:0] clamp_frac(input logic [FRACT_W-1:0] f);
		return (f > ONE_FR) ? ONE_FR : f;
	endfunction

	logic [CNT_W-1:0] n_d;
	logic [SUM_W-1:0] vsum_d;

	logic [VAL_W-1:0] own_s2;
	logic [VAL_W-1:0] bm_s2;
	logic [VAL_W-1:0] cm_s2;
	logic [CNT_W-1:0] n_s2;
	logic             elig_s2;
	logic [SUM_W-1:0] vsum_s2;
	logic [PK_W-1:0]  pk_s2;

	logic [VAL_W-1:0] toc;

	logic [VAL_W-1:0] bn_s3;
	logic [VAL_W-1:0] cn_s3;
	logic [CNT_W-1:0] n_s3;
	logic             elig_s3;
	logic             lt_s3;
	logic [VAL_W-1:0] own_s3;
	logic [VAL_W-1:0] bm_s3;
	logic [VAL_W-1:0] cm_s3;

	logic             att_d;

	logic             att_s4;
	logic [PK_W-1:0]  pmb_s4;
	logic [PK_W-1:0]  pmc_s4;
	logic [VAL_W-1:0] bn_s4;
	logic [VAL_W-1:0] cn_s4;
	logic [VAL_W-1:0] asum_s4;
	logic             elig_s4;
	logic [VAL_W-1:0] own_s4;
	logic [VAL_W-1:0] bm_s4;
	logic [VAL_W-1:0] cm_s4;

	logic [VAL_W-1:0] mb;
	logic [VAL_W-1:0] mc;

	// neighbour count and plain vapour sum over the neighbourhood
	always_comb begin
		n_d = '0;
		for (int q = 0; q < NBR_N; q++) begin
			n_d = n_d + CNT_W'(req.nbr_crystal_mask[q]);
		end
		vsum_d = sum_terms(req.own_vapour, nbr_list(req));
	end

	// stage 2: kappa product
	always_ff @(posedge clk) begin
		pk_s2   <= PK_W'(req.own_vapour) * PK_W'(clamp_frac(cfg.freeze_fraction));
		vsum_s2 <= vsum_d;
		n_s2    <= n_d;
		elig_s2 <= (req.cell_kind == KIND_VAPOUR) && (req.nbr_crystal_mask != '0);
		own_s2  <= req.own_vapour;
		bm_s2   <= req.boundary_mass_in;
		cm_s2   <= req.crystal_mass_in;
	end

	// crystal share is at most the vapour, so the boundary share never wraps
	assign toc = pk_s2[FRAC_W +: VAL_W];

	// stage 3: frozen masses and the vapour sum test
	always_ff @(posedge clk) begin
		bn_s3   <= sat_add(bm_s2, own_s2 - toc);
		cn_s3   <= sat_add(cm_s2, toc);
		lt_s3   <= vsum_s2 < SUM_W'(cfg.vapour_limit_three);
		n_s3    <= n_s2;
		elig_s3 <= elig_s2;
		own_s3  <= own_s2;
		bm_s3   <= bm_s2;
		cm_s3   <= cm_s2;
	end

	// attachment by crystal neighbour count
	always_comb begin
		if (n_s3 <= SPARSE_MAX) begin
			att_d = bn_s3 >= cfg.attach_threshold_sparse;
		end else if (n_s3 == THREE_NBR) begin
			att_d = (bn_s3 >= ONE_FX) || (lt_s3 && bn_s3 >= cfg.attach_threshold_three);
		end else begin
			att_d = 1'b1;
		end
	end

	// stage 4: melt products and the attached crystal mass
	always_ff @(posedge clk) begin
		att_s4  <= att_d;
		pmb_s4  <= PK_W'(bn_s3) * PK_W'(clamp_frac(cfg.melt_boundary_fraction));
		pmc_s4  <= PK_W'(cn_s3) * PK_W'(clamp_frac(cfg.melt_crystal_fraction));
		asum_s4 <= sat_add(cn_s3, bn_s3);
		bn_s4   <= bn_s3;
		cn_s4   <= cn_s3;
		elig_s4 <= elig_s3;
		own_s4  <= own_s3;
		bm_s4   <= bm_s3;
		cm_s4   <= cm_s3;
	end

	assign mb = pmb_s4[FRAC_W +: VAL_W];
	assign mc = pmc_s4[FRAC_W +: VAL_W];

	// phase 1 result: passthrough, attach, or melt
	always_comb begin
		if (!elig_s4) begin
			rsp.vapour_out        = own_s4;
			rsp.boundary_mass_out = bm_s4;
			rsp.crystal_mass_out  = cm_s4;
			rsp.attached          = 1'b0;
		end else if (att_s4) begin
			rsp.vapour_out        = '0;
			rsp.boundary_mass_out = '0;
			rsp.crystal_mass_out  = asum_s4;
			rsp.attached          = 1'b1;
		end else begin
			rsp.vapour_out        = sat_add(mb, mc);
			rsp.boundary_mass_out = bn_s4 - mb;
			rsp.crystal_mass_out  = cn_s4 - mc;
			rsp.attached          = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hex_snow_crystal_cell_update_unit.sv -----
// ----------------------------------------------------------------------------
// hex_snow_crystal_cell_update_unit: per-cell snow crystal update
// Diffusion and freeze/attach/melt phases of the hexagonal automaton in
// unsigned Q8.24, as a five-stage pipeline taking one cell per cycle.
//
//   channel   signals                         handshake
//   -------   -----------------------------   ------------------------------
//   request   start, busy, req                taken when start && !busy
//   result    done, rsp                       one-cycle strobe, no back-off
//   config    cfg_valid, cfg_ready,           write when cfg_valid &&
//             cfg_index, cfg_wdata            cfg_ready
//
// One request per cycle; a taken request passes through req_s1, the stage
// 2 to 4 registers and rsp_s5, and done rises with its result in rsp_s5.
// Both paths have the same register stages; the freeze path holds the kappa
// multiply, saturating mass update, melt multiply, then the output register.
// busy stays low: the pipeline never holds, since the receiver cannot stall.
// arst_n clears the stage valid bits and resets the configuration registers;
// requests in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_snow_crystal_cell_update_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  hsc_pkg::req_t                  req,
	output logic                           done,
	output hsc_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hsc_pkg::*;

	cfg_t cfg;
	logic accept;

	req_t req_s1;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic phase_s2;
	logic phase_s3;
	logic phase_s4;

	rsp_t dif_rsp;
	rsp_t frz_rsp;
	rsp_t rsp_s5;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	hsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// request capture and phase delay line
	always_ff @(posedge clk) begin
		req_s1   <= req;
		phase_s2 <= req_s1.req_type;
		phase_s3 <= phase_s2;
		phase_s4 <= phase_s3;
	end

	hsc_diffuse u_diffuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s4  (v_s4),
		.req       (req_s1),
		.far_field (cfg.far_field_vapour),
		.rsp       (dif_rsp)
	);

	hsc_freeze u_freeze (
		.clk (clk),
		.req (req_s1),
		.cfg (cfg),
		.rsp (frz_rsp)
	);

	// output register, pick the phase of the request
	always_ff @(posedge clk) begin
		rsp_s5 <= (phase_s4 == PHASE_DIFFUSE) ? dif_rsp : frz_rsp;
	end

	assign done = v_s5;
	assign rsp  = rsp_s5;

	// every accepted request comes out as a done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("result missing five cycles after request");

	// an attaching cell leaves no vapour and no boundary mass
	a_attach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.attached |-> rsp.vapour_out == '0 && rsp.boundary_mass_out == '0)
		else $error("attached cell kept vapour or boundary mass");

endmodule

`default_nettype wire
